[rtl/pgw_pkg.sv]
// ----------------------------------------------------------------------------
// pgw_pkg
// Shared types and constants for the page framebuffer glyph writer.
// ----------------------------------------------------------------------------
package pgw_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = 10;

  localparam logic [15:0] GLYPH_MSB  = 16'h8000;
  localparam logic [7:0]  BYTE_WHITE = 8'hFF;
  localparam logic [7:0]  BYTE_BLACK = 8'h00;

  typedef enum logic [2:0] {
    OP_FILL   = 3'd0,
    OP_CURSOR = 3'd1,
    OP_PIXEL  = 3'd2,
    OP_GLYPH  = 3'd3,
    OP_READ   = 3'd4
  } pgw_op_t;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_FILL  = 7'b0000100,
    ST_PIX   = 7'b0001000,
    ST_DRAIN = 7'b0010000,
    ST_READ  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } pgw_state_t;

endpackage

[rtl/page_framebuffer_glyph_writer.sv]
// ----------------------------------------------------------------------------
// page_framebuffer_glyph_writer
// Monochrome page-organized framebuffer with a text cursor and glyph-row
// drawing, built around one single-port-write, registered-read byte memory.
// ----------------------------------------------------------------------------
// Timing: one transaction is taken while the block is idle. Set cursor,
// refused glyph rows, glyph rows with nothing to draw, off-screen pixels,
// unused op codes and out-of-range reads go straight to the result state;
// a byte read passes through a read state first. A pixel draw or glyph row
// walks its columns in a read/modify/write pipeline, the memory port
// updating one column byte per cycle, and then drains the last write. A fill
// sweeps SCREEN_WIDTH * ceil(SCREEN_HEIGHT / 8) bytes at one byte per cycle.
// A finished result waits while the output register still holds an
// unaccepted one. After reset the same sweep clears the store, during which
// no input transaction is taken; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module page_framebuffer_glyph_writer
  import pgw_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata from bit 0: x[7:0], y[15:8], page[18:16], color[19], row_bits[35:20],
  // row_index[40:36], font_width[45:41], font_height[51:46], zero pad[55:52].
  input  logic [55:0] in_tdata,
  // tuser: op[2:0].
  input  logic [2:0]  in_tuser,
  input  logic        in_tlast,
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata from bit 0: read_data[7:0], cursor_col[15:8], cursor_row[23:16].
  output logic [23:0] out_tdata,
  // tuser: accepted[0].
  output logic        out_tuser,
  // Configuration: invert_colors in bit 0.
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic        cfg_tdata
);

  localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
  localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(STORE_BYTES - 1);

  // Input fields.
  logic [7:0]  f_x, f_y;
  logic [2:0]  f_page;
  logic        f_color;
  logic [15:0] f_row_bits;
  logic [4:0]  f_row_index, f_font_width;
  logic [5:0]  f_font_height;
  pgw_op_t     f_op;

  assign f_x           = in_tdata[7:0];
  assign f_y           = in_tdata[15:8];
  assign f_page        = in_tdata[18:16];
  assign f_color       = in_tdata[19];
  assign f_row_bits    = in_tdata[35:20];
  assign f_row_index   = in_tdata[40:36];
  assign f_font_width  = in_tdata[45:41];
  assign f_font_height = in_tdata[51:46];
  assign f_op          = pgw_op_t'(in_tuser);

  function automatic logic [ADDR_W-1:0] byte_addr(input logic [7:0] col,
                                                  input logic [2:0] pg);
    byte_addr = ADDR_W'(col) + ADDR_W'(pg) * ADDR_W'(SCREEN_WIDTH);
  endfunction

  pgw_state_t        state_r;
  logic [ADDR_W-1:0] sweep_r;
  logic [7:0]        fill_r;
  logic              invert_r;
  logic [7:0]        text_col_r, text_row_r;

  // Pixel walk state.
  logic [7:0]  col_r;
  logic [8:0]  row_r;
  logic [4:0]  cnt_r;
  logic [15:0] bits_r;
  logic        color_r;

  // Modify/write stage.
  logic              pv_r;
  logic [ADDR_W-1:0] pa_r;
  logic [7:0]        pmask_r;
  logic              pwhite_r;

  // Result and output registers.
  logic [7:0]  res_rd_r;
  logic        res_acc_r;
  logic        out_valid_r;
  logic [23:0] out_data_r;
  logic        out_acc_r;

  // Memory.
  logic [7:0]        mem [0:STORE_DEPTH-1];
  logic [7:0]        rdata_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata;

  logic        in_fire;
  logic        pix_on_screen, read_in_range, glyph_room, glyph_draw;
  logic [8:0]  glyph_row;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_tready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_acc_r;

  assign pix_on_screen = ({1'b0, f_x} < 9'(SCREEN_WIDTH)) &&
                         ({1'b0, f_y} < 9'(SCREEN_HEIGHT));
  assign read_in_range = ({1'b0, f_x} < 9'(SCREEN_WIDTH)) &&
                         ({1'b0, f_page} < 4'(PAGES));
  assign glyph_room    = (({1'b0, text_col_r} + 9'(f_font_width)) < 9'(SCREEN_WIDTH)) &&
                         (({1'b0, text_row_r} + 9'(f_font_height)) < 9'(SCREEN_HEIGHT));
  assign glyph_row     = {1'b0, text_row_r} + 9'(f_row_index);
  assign glyph_draw    = (glyph_row < 9'(SCREEN_HEIGHT)) && (f_font_width != 5'd0);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pa_r;
    mem_wdata = pwhite_r ? (rdata_r | pmask_r) : (rdata_r & ~pmask_r);
    if ((state_r == ST_CLEAR) || (state_r == ST_FILL)) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_r;
      mem_wdata = fill_r;
    end else if (pv_r) begin
      mem_we = 1'b1;
    end
    if (state_r == ST_PIX) begin
      mem_raddr = byte_addr(col_r, row_r[5:3]);
    end else begin
      mem_raddr = byte_addr(f_x, f_page);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= 1'b0;
    end else if (cfg_tvalid && cfg_tready) begin
      invert_r <= cfg_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sweep_r     <= '0;
      fill_r      <= BYTE_BLACK;
      text_col_r  <= '0;
      text_row_r  <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == ST_DONE) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR, ST_FILL: begin
          sweep_r <= sweep_r + ADDR_W'(1);
          if (sweep_r == SWEEP_LAST) begin
            state_r <= (state_r == ST_CLEAR) ? ST_IDLE : ST_DONE;
          end
        end
        ST_IDLE: begin
          res_rd_r  <= '0;
          res_acc_r <= !(in_fire && (f_op == OP_GLYPH) && !glyph_room);
          if (in_fire) begin
            bits_r  <= (f_op == OP_PIXEL) ? GLYPH_MSB : f_row_bits;
            color_r <= f_color;
            unique case (f_op)
              OP_FILL: begin
                sweep_r <= '0;
                fill_r  <= f_color ? BYTE_WHITE : BYTE_BLACK;
                state_r <= ST_FILL;
              end
              OP_CURSOR: begin
                text_col_r <= f_x;
                text_row_r <= f_y;
                state_r    <= ST_DONE;
              end
              OP_PIXEL: begin
                col_r   <= f_x;
                row_r   <= {1'b0, f_y};
                cnt_r   <= 5'd1;
                state_r <= pix_on_screen ? ST_PIX : ST_DONE;
              end
              OP_GLYPH: begin
                col_r <= text_col_r;
                row_r <= glyph_row;
                cnt_r <= f_font_width;
                if (!glyph_room) begin
                  state_r <= ST_DONE;
                end else begin
                  if (in_tlast) begin
                    text_col_r <= text_col_r + 8'(f_font_width);
                  end
                  state_r <= glyph_draw ? ST_PIX : ST_DONE;
                end
              end
              OP_READ: begin
                state_r <= read_in_range ? ST_READ : ST_DONE;
              end
              default: begin
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_PIX: begin
          // The byte read this cycle is modified and written back next cycle.
          pv_r     <= 1'b1;
          pa_r     <= byte_addr(col_r, row_r[5:3]);
          pmask_r  <= 8'(1) << row_r[2:0];
          pwhite_r <= (bits_r[15] ? color_r : ~color_r) ^ invert_r;
          bits_r   <= bits_r << 1;
          col_r    <= col_r + 8'd1;
          cnt_r    <= cnt_r - 5'd1;
          if (cnt_r == 5'd1) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          pv_r    <= 1'b0;
          state_r <= ST_DONE;
        end
        ST_READ: begin
          res_rd_r <= rdata_r;
          state_r  <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_data_r <= {text_row_r, text_col_r, res_rd_r};
            out_acc_r  <= res_acc_r;
            state_r    <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // The write stage must be empty whenever a new transaction can enter.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !pv_r)
    else $error("pending pixel write while accepting a transaction");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_we)
    else $error("memory written while idle");

  a_pix_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PIX) |=> ((state_r == ST_PIX) || (state_r == ST_DRAIN)))
    else $error("pixel walk left without draining");

  a_drain_has_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (pv_r && mem_we))
    else $error("drain without a pending write");

  a_done_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> !pv_r)
    else $error("result issued before last write");

endmodule
